// ===== src/status_beacon_job_done_detector_assert.svh =====
// assertion macros for the checker file of the beacon job-done detector
// no dependencies; expects clk and rst_n in the scope of each use
`ifndef STATUS_BEACON_JOB_DONE_DETECTOR_ASSERT_SVH
`define STATUS_BEACON_JOB_DONE_DETECTOR_ASSERT_SVH

// checked only outside reset
`define SBJD_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SBJD_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/sbjd_pkg.sv =====
// types, codes and constants of the beacon job-done detector
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package sbjd_pkg;

  // state class codes of a beacon
  typedef enum logic [2:0] {
    CLS_NONE  = 3'd0,
    CLS_RUN   = 3'd1,
    CLS_IDLE  = 3'd2,
    CLS_ALARM = 3'd3,
    CLS_CHECK = 3'd4,
    CLS_OTHER = 3'd5
  } cls_t;

  // one request on the input channel
  typedef struct packed {
    logic        cmd;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [62:0] now_us;
  } in_item_t;

  // one request on the result channel
  typedef struct packed {
    logic       accepted;
    logic [2:0] state_class;
    logic       changing;
    logic       job_done;
  } out_item_t;

  // parser verdict handed to the detector stage
  typedef struct packed {
    logic res;
    logic tick;
    logic accepted;
    cls_t cls;
    logic chg;
  } verdict_t;

  localparam logic        CMD_BYTE = 1'b0;
  localparam logic        CMD_TICK = 1'b1;
  localparam logic [31:0] STABLE_RESET = 32'd2_500_000;

  localparam logic [7:0] CH_OPEN  = 8'h3C;  // '<'
  localparam logic [7:0] CH_CLOSE = 8'h3E;  // '>'
  localparam logic [7:0] CH_BAR   = 8'h7C;  // '|'
  localparam logic [7:0] CH_COLON = 8'h3A;  // ':'

endpackage

// ===== src/sbjd_in_stage.sv =====
// input register of the beacon job-done detector
// depends on sbjd_pkg
`timescale 1ns / 1ps

module sbjd_in_stage import sbjd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     blocked,
  output logic     s1_valid,
  output in_item_t s1_item,
  output logic     fire
);

  logic     s1_valid_r, s1_valid_nxt;
  in_item_t s1_item_r;
  logic     take;

  assign fire     = s1_valid_r && !blocked;
  assign in_stall = s1_valid_r && blocked;
  assign take     = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_item_r <= in_data;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

// ===== src/sbjd_parser.sv =====
// beacon framing and field parser of the beacon job-done detector
// depends on sbjd_pkg
`timescale 1ns / 1ps

module sbjd_parser import sbjd_pkg::*; #(
  parameter int PACKET_MAX = 159
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  in_item_t item,
  output verdict_t verdict
);

  localparam int CNT_W = $clog2(PACKET_MAX + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(PACKET_MAX);
  localparam logic [CNT_W-1:0] TWO_CNT = CNT_W'(2);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  // candidate flag bits of the current field
  localparam int FM_CHG   = 0;
  localparam int FM_SEQ   = 1;
  localparam int FM_ON    = 2;
  localparam int FM_RUN   = 3;
  localparam int FM_IDLE  = 4;
  localparam int FM_ALARM = 5;
  localparam int FM_CHECK = 6;
  localparam int FM_COLON = 7;
  localparam logic [7:0] FM_START = 8'h7F;

  localparam logic [71:0] CHG_TXT   = 72'("Changing=");
  localparam logic [71:0] SEQ_TXT   = 72'("Seq=");
  localparam logic [71:0] ON_TXT    = 72'("On");
  localparam logic [71:0] RUN_TXT   = 72'("Run");
  localparam logic [71:0] IDLE_TXT  = 72'("Idle");
  localparam logic [71:0] ALARM_TXT = 72'("Alarm");
  localparam logic [71:0] CHECK_TXT = 72'("Check");

  typedef struct packed {
    logic [7:0] pos;
    logic [7:0] flags;
    logic       ms_seen;
    cls_t       ms_code;
    logic       chg;
  } field_st_t;

  localparam field_st_t FIELD_CLEAR = '{pos: 8'd0, flags: FM_START, ms_seen: 1'b0,
                                         ms_code: CLS_NONE, chg: 1'b0};

  // character c sits at position p of a right-aligned text of length len
  function automatic logic txt_hit(input logic [71:0] txt, input int unsigned len,
                                   input logic [7:0] p, input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    if (32'(p) < len) begin
      hit = (c == txt[8 * (len - 1 - 32'(p)) +: 8]);
    end
    return hit;
  endfunction

  // cut at ':' or field end: keep only candidates of matching length
  function automatic logic [7:0] cand_cut(input logic [7:0] f, input logic [7:0] len);
    logic [7:0] r;
    r = f;
    if (len != 8'd3) r[FM_RUN] = 1'b0;
    if (len != 8'd4) r[FM_IDLE] = 1'b0;
    if (len != 8'd5) begin
      r[FM_ALARM] = 1'b0;
      r[FM_CHECK] = 1'b0;
    end
    r[FM_COLON] = 1'b1;
    return r;
  endfunction

  function automatic field_st_t field_end(input field_st_t s);
    field_st_t  r;
    logic [7:0] f;
    r = s;
    f = s.flags;
    if (s.pos != 8'd0) begin
      if (f[FM_CHG] && s.pos >= 8'd9) begin
        r.chg = f[FM_ON] && (s.pos == 8'd11);
      end else if (f[FM_SEQ] && s.pos >= 8'd4) begin
        r.chg = s.chg;  // sequence fields are skipped
      end else if (!s.ms_seen) begin
        if (!f[FM_COLON]) f = cand_cut(f, s.pos);
        if (f[FM_RUN])        r.ms_code = CLS_RUN;
        else if (f[FM_IDLE])  r.ms_code = CLS_IDLE;
        else if (f[FM_ALARM]) r.ms_code = CLS_ALARM;
        else if (f[FM_CHECK]) r.ms_code = CLS_CHECK;
        else                  r.ms_code = CLS_OTHER;
        r.ms_seen = 1'b1;
      end
    end
    r.pos   = 8'd0;
    r.flags = FM_START;
    return r;
  endfunction

  function automatic field_st_t body_char(input field_st_t s, input logic [7:0] c);
    field_st_t  r;
    logic [7:0] f;
    logic [7:0] p;
    r = s;
    f = s.flags;
    p = s.pos;
    if (c == CH_BAR) begin
      r = field_end(s);
    end else begin
      if (p < 8'd9) begin
        if (!txt_hit(CHG_TXT, 9, p, c)) f[FM_CHG] = 1'b0;
      end else begin
        if (!txt_hit(ON_TXT, 2, p - 8'd9, c)) f[FM_ON] = 1'b0;
      end
      if (!txt_hit(SEQ_TXT, 4, p, c)) f[FM_SEQ] = 1'b0;
      if (!f[FM_COLON]) begin
        if (c == CH_COLON) begin
          f = cand_cut(f, p);
        end else begin
          if (!txt_hit(RUN_TXT, 3, p, c))   f[FM_RUN]   = 1'b0;
          if (!txt_hit(IDLE_TXT, 4, p, c))  f[FM_IDLE]  = 1'b0;
          if (!txt_hit(ALARM_TXT, 5, p, c)) f[FM_ALARM] = 1'b0;
          if (!txt_hit(CHECK_TXT, 5, p, c)) f[FM_CHECK] = 1'b0;
        end
      end
      r.flags = f;
      if (p != 8'hFF) r.pos = p + 8'd1;
    end
    return r;
  endfunction

  logic [CNT_W-1:0] bc_r, bc_nxt;
  logic             frame_ok_r, frame_ok_nxt;
  logic [7:0]       pend_r, pend_nxt;
  field_st_t        fs_r, fs_nxt;
  field_st_t        fs_fin;
  logic             well_framed;

  always_comb begin
    bc_nxt       = bc_r;
    frame_ok_nxt = frame_ok_r;
    pend_nxt     = pend_r;
    fs_nxt       = fs_r;
    fs_fin       = FIELD_CLEAR;
    well_framed  = 1'b0;
    verdict      = '{res: 1'b0, tick: 1'b0, accepted: 1'b0, cls: CLS_NONE, chg: 1'b0};
    if (item.cmd == CMD_TICK) begin
      // a tick drops any partial packet
      verdict.res  = 1'b1;
      verdict.tick = 1'b1;
      bc_nxt       = '0;
      frame_ok_nxt = 1'b0;
      pend_nxt     = 8'd0;
      fs_nxt       = FIELD_CLEAR;
    end else begin
      if (bc_r < MAX_CNT) begin
        if (bc_r == '0) begin
          frame_ok_nxt = (item.data_byte == CH_OPEN);
        end else begin
          if (bc_r >= TWO_CNT) fs_nxt = body_char(fs_r, pend_r);
          pend_nxt = item.data_byte;
        end
        bc_nxt = bc_r + ONE_CNT;
      end
      if (item.last_byte) begin
        fs_fin      = field_end(fs_nxt);
        well_framed = frame_ok_nxt && (bc_nxt >= TWO_CNT) && (pend_nxt == CH_CLOSE);
        verdict.res = 1'b1;
        if (well_framed && fs_fin.ms_seen) begin
          verdict.accepted = 1'b1;
          verdict.cls      = fs_fin.ms_code;
          verdict.chg      = fs_fin.chg;
        end
        bc_nxt       = '0;
        frame_ok_nxt = 1'b0;
        pend_nxt     = 8'd0;
        fs_nxt       = FIELD_CLEAR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r       <= '0;
      frame_ok_r <= 1'b0;
      pend_r     <= 8'd0;
      fs_r       <= FIELD_CLEAR;
    end else if (fire) begin
      bc_r       <= bc_nxt;
      frame_ok_r <= frame_ok_nxt;
      pend_r     <= pend_nxt;
      fs_r       <= fs_nxt;
    end
  end

endmodule

// ===== src/sbjd_detect.sv =====
// arming, stable window and result register of the beacon job-done detector
// depends on sbjd_pkg
`timescale 1ns / 1ps

module sbjd_detect import sbjd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        fire,
  input  verdict_t    verdict,
  input  logic [62:0] now_us,
  input  logic        out_stall,
  output logic        out_valid,
  output out_item_t   out_data
);

  logic [31:0] window_r;
  logic        run_seen_r, run_seen_nxt;
  logic        done_fired_r, done_fired_nxt;
  logic        win_open_r, win_open_nxt;
  logic [62:0] win_start_r, win_start_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r;
  logic [63:0] diff;
  logic        elapsed;
  logic        done;
  logic        emit;

  assign diff    = {1'b0, now_us} - {1'b0, win_start_r};
  assign elapsed = win_open_r && !diff[63] && (diff[62:0] >= {31'd0, window_r});
  assign emit    = fire && verdict.res;

  always_comb begin
    run_seen_nxt   = run_seen_r;
    done_fired_nxt = done_fired_r;
    win_open_nxt   = win_open_r;
    win_start_nxt  = win_start_r;
    done           = 1'b0;
    if (verdict.tick) begin
      if (run_seen_r && !done_fired_r && elapsed) begin
        done_fired_nxt = 1'b1;
        done           = 1'b1;
      end
    end else if (verdict.accepted) begin
      case (verdict.cls) inside
        CLS_RUN: begin
          run_seen_nxt   = 1'b1;
          done_fired_nxt = 1'b0;
          win_open_nxt   = 1'b0;
        end
        CLS_ALARM, CLS_CHECK: begin
          run_seen_nxt = 1'b0;
          win_open_nxt = 1'b0;
        end
        default: begin
          if (run_seen_r && !done_fired_r) begin
            if (verdict.cls == CLS_IDLE && !verdict.chg) begin
              if (!win_open_r) begin
                win_open_nxt  = 1'b1;
                win_start_nxt = now_us;
              end else if (elapsed) begin
                done_fired_nxt = 1'b1;
                done           = 1'b1;
              end
            end else begin
              win_open_nxt = 1'b0;
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= STABLE_RESET;
      run_seen_r   <= 1'b0;
      done_fired_r <= 1'b0;
      win_open_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) window_r <= cfg_wdata;
      if (fire) begin
        run_seen_r   <= run_seen_nxt;
        done_fired_r <= done_fired_nxt;
        win_open_r   <= win_open_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) win_start_r <= win_start_nxt;
    if (emit) begin
      out_data_r <= '{accepted: verdict.accepted, state_class: verdict.cls,
                      changing: verdict.chg, job_done: done};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/status_beacon_job_done_detector.sv =====
// top level of the beacon job-done detector: input register, parser, detector
// depends on sbjd_pkg, sbjd_in_stage, sbjd_parser and sbjd_detect
`timescale 1ns / 1ps

// Watches machine status beacons, one byte per request, and poll ticks, each
// stamped with a microsecond time. A beacon is '<' fields '>' with fields
// split by '|'. The first field that is neither empty, a Seq= field nor a
// Changing= field gives the main state (cut at ':'); Changing=On sets the
// changing flag. Run arms detection, Alarm or Check disarms it, and Idle
// without changing held for stable_window_us raises job_done once per run.
// One result leaves per tick and per last byte of a beacon, none for the
// other bytes. Only the first PACKET_MAX bytes of a beacon are parsed; later
// bytes are dropped until its last byte. The block takes one request every
// cycle while in_stall is low: a request is held in the input register, and
// its result is written to the result register when it leaves there. A
// request that produces a result waits in the input register only while a
// previous result is held in the result register by out_stall; plain body
// bytes never wait. The stable window is one 64-bit subtract of the 63-bit
// times and a compare against the configuration register. No clearing pass
// follows reset. The window register is written at any cycle (cfg_ready is
// always high) but is meant to change only while no beacon is in flight.

module status_beacon_job_done_detector import sbjd_pkg::*; #(
  parameter int PACKET_MAX = 159
) (
  input  logic        clk,
  input  logic        rst_n,
  // input requests
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  // result requests
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  // stable window register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic     s1_valid;
  in_item_t s1_item;
  logic     fire;
  logic     blocked;
  verdict_t verdict;

  // only a request that yields a result needs room in the result register
  assign blocked   = out_valid && out_stall && (s1_item.cmd || s1_item.last_byte);
  assign cfg_ready = 1'b1;

  sbjd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .blocked  (blocked),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .fire     (fire)
  );

  // parser state advances only on a request leaving the input register
  sbjd_parser #(
    .PACKET_MAX (PACKET_MAX)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire && s1_valid),
    .item    (s1_item),
    .verdict (verdict)
  );

  sbjd_detect u_det (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_wdata (cfg_data),
    .fire      (fire),
    .verdict   (verdict),
    .now_us    (s1_item.now_us),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== src/sbjd_checker.sv =====
// port-level checks on the result channel of the beacon job-done detector
// depends on sbjd_pkg and status_beacon_job_done_detector_assert.svh
`timescale 1ns / 1ps
`include "status_beacon_job_done_detector_assert.svh"

module sbjd_checker import sbjd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // no result straight after reset
  `SBJD_CHECK_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result valid after reset")

  // a held result keeps its payload
  `SBJD_CHECK(a_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "held result changed")

  // rejected beacons and ticks carry no class and no changing flag
  `SBJD_CHECK(a_reject_clean, out_valid && !out_data.accepted |-> out_data.state_class == CLS_NONE && !out_data.changing, "rejected result carries a class")

  // completion only on a tick or on steady idle
  `SBJD_CHECK(a_done_src, out_valid && out_data.job_done |-> !out_data.accepted || (out_data.state_class == CLS_IDLE && !out_data.changing), "job done on wrong state")

endmodule

bind status_beacon_job_done_detector sbjd_checker u_sbjd_chk (.*);
